/* design/bspch_pkg.sv */
// Shared types and codes for the clip hull point classifier.
`default_nettype none

package bspch_pkg;

	// Item function codes.
	localparam logic [1:0] FuncNode     = 2'd0;
	localparam logic [1:0] FuncPlane    = 2'd1;
	localparam logic [1:0] FuncClassify = 2'd2;

	// Walk status codes.
	localparam logic [2:0] StLeaf     = 3'd0;
	localparam logic [2:0] StNoHull   = 3'd1;
	localparam logic [2:0] StBadPlane = 3'd2;
	localparam logic [2:0] StBadNode  = 3'd3;
	localparam logic [2:0] StLimit    = 3'd4;

	// Child code that marks solid contents.
	localparam logic [15:0] ChildSolid = 16'hFFFE;

	// Q1.14 unit used for the starting face normal.
	localparam logic [15:0] FaceOne = 16'h4000;

	// Width of the plane distance accumulator.
	localparam int DistW = 52;

	// Configuration registers as seen by the walker.
	typedef struct packed {
		logic [12:0] head_node;
		logic [12:0] node_count;
		logic [12:0] plane_count;
	} cfg_t;

	// One node table entry.
	typedef struct packed {
		logic [11:0] pref;
		logic [15:0] front;
		logic [15:0] back;
	} node_word_t;

	// One plane table entry.
	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [31:0] offset;
	} plane_word_t;

	localparam int NodeW  = $bits(node_word_t);
	localparam int PlaneW = $bits(plane_word_t);

endpackage

`default_nettype wire

/* design/bspch_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bspch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/bspch_regs.sv */
// APB configuration registers of the clip hull point classifier.
`default_nettype none

module bspch_regs
	import bspch_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	localparam logic [1:0] RegHead      = 2'd0;
	localparam logic [1:0] RegNodeCount = 2'd1;
	localparam logic [1:0] RegPlaneCnt  = 2'd2;

	cfg_t        cfg_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes; an address beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_node   <= 13'h1FFF;
			cfg_q.node_count  <= 13'd0;
			cfg_q.plane_count <= 13'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegHead:      cfg_q.head_node   <= pwdata[12:0];
				RegNodeCount: cfg_q.node_count  <= pwdata[12:0];
				RegPlaneCnt:  cfg_q.plane_count <= pwdata[12:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// Read data; the head node reads back sign extended.
	always_comb begin
		unique case (reg_idx)
			RegHead:      prdata = {{19{cfg_q.head_node[12]}}, cfg_q.head_node};
			RegNodeCount: prdata = {19'd0, cfg_q.node_count};
			RegPlaneCnt:  prdata = {19'd0, cfg_q.plane_count};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

/* design/bspch_walk.sv */
// Tree walker: loads table entries and walks the hull for classify items.
`default_nettype none

module bspch_walk
	import bspch_pkg::*;
#(
	parameter int NODE_DEPTH  = 4096,
	parameter int PLANE_DEPTH = 4096,
	parameter int MAX_STEPS   = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cfg_t                           cfg,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     func,
	input  wire logic [11:0]                    slot,
	input  wire logic [11:0]                    plane_ref,
	input  wire logic [15:0]                    front_child,
	input  wire logic [15:0]                    back_child,
	input  wire logic [15:0]                    normal_x,
	input  wire logic [15:0]                    normal_y,
	input  wire logic [15:0]                    normal_z,
	input  wire logic [31:0]                    plane_offset,
	input  wire logic [31:0]                    point_x,
	input  wire logic [31:0]                    point_y,
	input  wire logic [31:0]                    point_z,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                is_solid,
	output logic      [15:0]                    face_x,
	output logic      [15:0]                    face_y,
	output logic      [15:0]                    face_z,
	output logic      [2:0]                     status,
	output logic                                node_we,
	output logic      [$clog2(NODE_DEPTH)-1:0]  node_waddr,
	output node_word_t                          node_wdata,
	output logic                                node_re,
	output logic      [$clog2(NODE_DEPTH)-1:0]  node_raddr,
	input  wire node_word_t                     node_rdata,
	output logic                                plane_we,
	output logic      [$clog2(PLANE_DEPTH)-1:0] plane_waddr,
	output plane_word_t                         plane_wdata,
	output logic                                plane_re,
	output logic      [$clog2(PLANE_DEPTH)-1:0] plane_raddr,
	input  wire plane_word_t                    plane_rdata
);

	localparam int NAW = $clog2(NODE_DEPTH);
	localparam int PAW = $clog2(PLANE_DEPTH);
	localparam int SW  = $clog2(MAX_STEPS + 1);
	localparam logic [16:0] NodeLim  = 17'(NODE_DEPTH);
	localparam logic [16:0] PlaneLim = 17'(PLANE_DEPTH);
	localparam logic [SW-1:0] StepLim = SW'(MAX_STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PLANE,
		S_MUL,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [1:0]      k_q;
	logic [SW-1:0]   steps_q;
	logic [15:0]     fx_q, fy_q, fz_q;
	logic            solid_q;
	logic [2:0]      status_q;
	logic            out_valid_q;

	logic [31:0]             px_q, py_q, pz_q;
	logic signed [47:0]      prod_q;
	logic signed [DistW-1:0] acc_q;

	logic                    accept;
	logic                    head_neg;
	logic                    no_hull;
	logic                    head_bad;
	logic                    pref_bad;
	logic signed [15:0]      op_n;
	logic signed [31:0]      op_p;
	logic signed [47:0]      mul_c;
	logic signed [DistW-1:0] off_sh;
	logic signed [DistW-1:0] dsum;
	logic                    front;
	logic [15:0]             next_node;
	logic                    next_bad;
	logic [SW-1:0]           steps_next;
	logic [15:0]             nfx, nfy, nfz;

	// True when a node index is at or beyond the usable node count.
	function automatic logic node_oob(input logic [15:0] idx, input logic [12:0] cnt);
		logic [16:0] w;
		w = {1'b0, idx};
		return (w >= {4'd0, cnt}) || (w >= NodeLim);
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Table writes for load items; slots beyond the depth are dropped.
	assign node_we     = accept && (func == FuncNode) && ({5'd0, slot} < NodeLim);
	assign node_waddr  = NAW'(slot);
	assign node_wdata  = '{pref: plane_ref, front: front_child, back: back_child};
	assign plane_we    = accept && (func == FuncPlane) && ({5'd0, slot} < PlaneLim);
	assign plane_waddr = PAW'(slot);
	assign plane_wdata = '{nx: normal_x, ny: normal_y, nz: normal_z, offset: plane_offset};

	// Hull checks at the head node and at a node entry.
	assign head_neg = cfg.head_node[12];
	assign no_hull  = head_neg || (cfg.node_count == 13'd0);
	assign head_bad = node_oob({3'd0, cfg.head_node}, cfg.node_count);
	assign pref_bad = ({5'd0, node_rdata.pref} >= {4'd0, cfg.plane_count})
		|| ({5'd0, node_rdata.pref} >= PlaneLim);

	// Operand selection for the shared multiplier, one product per cycle.
	always_comb begin
		unique case (k_q)
			2'd0: begin
				op_n = $signed(plane_rdata.nx);
				op_p = $signed(px_q);
			end
			2'd1: begin
				op_n = $signed(plane_rdata.ny);
				op_p = $signed(py_q);
			end
			default: begin
				op_n = $signed(plane_rdata.nz);
				op_p = $signed(pz_q);
			end
		endcase
	end

	assign mul_c  = op_n * op_p;
	assign off_sh = {{6{plane_rdata.offset[31]}}, plane_rdata.offset, 14'd0};

	// Side decision once the last product is in.
	assign dsum       = acc_q + {{(DistW - 48){prod_q[47]}}, prod_q};
	assign front      = !dsum[DistW-1];
	assign next_node  = front ? node_rdata.front : node_rdata.back;
	assign next_bad   = node_oob(next_node, cfg.node_count);
	assign steps_next = steps_q + SW'(1);
	assign nfx = front ? (~plane_rdata.nx + 16'd1) : plane_rdata.nx;
	assign nfy = front ? (~plane_rdata.ny + 16'd1) : plane_rdata.ny;
	assign nfz = front ? (~plane_rdata.nz + 16'd1) : plane_rdata.nz;

	// Memory read requests: head node on accept, child node after a decision.
	always_comb begin
		node_re     = 1'b0;
		node_raddr  = NAW'(cfg.head_node);
		plane_re    = (state_q == S_PLANE) && !pref_bad;
		plane_raddr = PAW'(node_rdata.pref);
		if (state_q == S_IDLE) begin
			node_re = accept && (func == FuncClassify) && !no_hull && !head_bad;
		end else if (state_q == S_MUL && k_q == 2'd3) begin
			node_re    = !next_node[15] && (steps_next != StepLim) && !next_bad;
			node_raddr = NAW'(next_node);
		end
	end

	// Distance datapath: point capture, product and running sum.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_c;
			if (k_q == 2'd0) begin
				acc_q <= -off_sh;
			end else begin
				acc_q <= dsum;
			end
		end
	end

	// Walk sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 2'd0;
			steps_q     <= '0;
			fx_q        <= 16'd0;
			fy_q        <= 16'd0;
			fz_q        <= FaceOne;
			solid_q     <= 1'b0;
			status_q    <= StLeaf;
			out_valid_q <= 1'b0;
			is_solid    <= 1'b0;
			face_x      <= 16'd0;
			face_y      <= 16'd0;
			face_z      <= 16'd0;
			status      <= StLeaf;
		end else begin
			// A taken result beat empties the output register unless a new one loads.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && func == FuncClassify) begin
						fx_q    <= 16'd0;
						fy_q    <= 16'd0;
						fz_q    <= FaceOne;
						solid_q <= 1'b0;
						steps_q <= '0;
						if (no_hull) begin
							status_q <= StNoHull;
							state_q  <= S_DONE;
						end else if (head_bad) begin
							status_q <= StBadNode;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_PLANE;
						end
					end
				end
				S_PLANE: begin
					k_q <= 2'd0;
					if (pref_bad) begin
						status_q <= StBadPlane;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						fx_q    <= nfx;
						fy_q    <= nfy;
						fz_q    <= nfz;
						steps_q <= steps_next;
						if (next_node[15]) begin
							solid_q  <= (next_node == ChildSolid);
							status_q <= StLeaf;
							state_q  <= S_DONE;
						end else if (steps_next == StepLim) begin
							status_q <= StLimit;
							state_q  <= S_DONE;
						end else if (next_bad) begin
							status_q <= StBadNode;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_PLANE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						is_solid    <= solid_q;
						face_x      <= fx_q;
						face_y      <= fy_q;
						face_z      <= fz_q;
						status      <= status_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/bsp_clip_hull_point_solid.sv */
// Top level of the clip hull point classifier.
// Each load item writes one table entry; a slot beyond the table depth is dropped.
// A classify item walks the hull node by node: for each node a plane read, then
// the x, y and z products and the side decision, with the next node read overlapping the decision.
// A finished result waits in an output register while the next item is accepted.
// Reset sets head_node to -1 and both counts to 0; the tables are not cleared.
`default_nettype none

module bsp_clip_hull_point_solid
	import bspch_pkg::*;
#(
	parameter int NODE_DEPTH  = 4096,
	parameter int PLANE_DEPTH = 4096,
	parameter int MAX_STEPS   = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [11:0] slot,
	input  wire logic [11:0] plane_ref,
	input  wire logic [15:0] front_child,
	input  wire logic [15:0] back_child,
	input  wire logic [15:0] normal_x,
	input  wire logic [15:0] normal_y,
	input  wire logic [15:0] normal_z,
	input  wire logic [31:0] plane_offset,
	input  wire logic [31:0] point_x,
	input  wire logic [31:0] point_y,
	input  wire logic [31:0] point_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_solid,
	output logic      [15:0] face_x,
	output logic      [15:0] face_y,
	output logic      [15:0] face_z,
	output logic      [2:0]  status
);

	localparam int NAW = $clog2(NODE_DEPTH);
	localparam int PAW = $clog2(PLANE_DEPTH);

	cfg_t           cfg;
	logic           node_we, node_re, plane_we, plane_re;
	logic [NAW-1:0] node_waddr, node_raddr;
	logic [PAW-1:0] plane_waddr, plane_raddr;
	node_word_t     node_wdata, node_rdata;
	plane_word_t    plane_wdata, plane_rdata;

	// Configuration registers.
	bspch_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Node table.
	bspch_ram #(
		.WIDTH (NodeW),
		.DEPTH (NODE_DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	// Plane table: normal and offset in one word.
	bspch_ram #(
		.WIDTH (PlaneW),
		.DEPTH (PLANE_DEPTH)
	) u_plane_ram (
		.clk   (clk),
		.we    (plane_we),
		.waddr (plane_waddr),
		.wdata (plane_wdata),
		.re    (plane_re),
		.raddr (plane_raddr),
		.rdata (plane_rdata)
	);

	// Walk sequencer and distance datapath.
	bspch_walk #(
		.NODE_DEPTH  (NODE_DEPTH),
		.PLANE_DEPTH (PLANE_DEPTH),
		.MAX_STEPS   (MAX_STEPS)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.slot         (slot),
		.plane_ref    (plane_ref),
		.front_child  (front_child),
		.back_child   (back_child),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.plane_offset (plane_offset),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_solid     (is_solid),
		.face_x       (face_x),
		.face_y       (face_y),
		.face_z       (face_z),
		.status       (status),
		.node_we      (node_we),
		.node_waddr   (node_waddr),
		.node_wdata   (node_wdata),
		.node_re      (node_re),
		.node_raddr   (node_raddr),
		.node_rdata   (node_rdata),
		.plane_we     (plane_we),
		.plane_waddr  (plane_waddr),
		.plane_wdata  (plane_wdata),
		.plane_re     (plane_re),
		.plane_raddr  (plane_raddr),
		.plane_rdata  (plane_rdata)
	);

endmodule

`default_nettype wire
